/* design/lsnm_pkg.sv */
// ----------------------------------------------------------------------------
// Letterbox nearest scaler map package
// Shared widths, register codes, reset values and payload types, plus the
// single-bit step of the restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

package lsnm_pkg;

  localparam int PosW          = 13;  // frame positions and source indexes
  localparam int SizeW         = 14;  // size registers
  localparam int QuotW         = 14;  // quotient is below the source size
  localparam int ProdW         = PosW + SizeW;
  localparam int StepsPerStage = 2;
  localparam int NumDivStages  = QuotW / StepsPerStage;
  localparam int CfgIdxW       = 3;

  localparam logic [PosW-1:0] IndexMax = '1;

  localparam logic [SizeW-1:0] FrameWidthRst  = SizeW'(640);
  localparam logic [SizeW-1:0] FrameHeightRst = SizeW'(480);
  localparam logic [PosW-1:0]  BoxLeftRst     = '0;
  localparam logic [PosW-1:0]  BoxTopRst      = '0;
  localparam logic [SizeW-1:0] BoxWidthRst    = SizeW'(640);
  localparam logic [SizeW-1:0] BoxHeightRst   = SizeW'(480);
  localparam logic [SizeW-1:0] SourceWidthRst = SizeW'(640);
  localparam logic [SizeW-1:0] SourceHeightRst = SizeW'(480);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_BOX_LEFT      = 3'd2,
    CFG_BOX_TOP       = 3'd3,
    CFG_BOX_WIDTH     = 3'd4,
    CFG_BOX_HEIGHT    = 3'd5,
    CFG_SOURCE_WIDTH  = 3'd6,
    CFG_SOURCE_HEIGHT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [SizeW-1:0] frame_width;
    logic [SizeW-1:0] frame_height;
    logic [PosW-1:0]  box_left;
    logic [PosW-1:0]  box_top;
    logic [SizeW-1:0] box_width;
    logic [SizeW-1:0] box_height;
    logic [SizeW-1:0] source_width;
    logic [SizeW-1:0] source_height;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
  } in_t;

  typedef struct packed {
    logic            in_picture;
    logic [PosW-1:0] src_col;
    logic [PosW-1:0] src_row;
    logic            outside_frame;
  } out_t;

  // Control bits that travel alongside the arithmetic.
  typedef struct packed {
    logic valid;
    logic in_box;
    logic outside;
  } flags_t;

  // Partial remainder and the word that trades dividend bits for quotient bits.
  typedef struct packed {
    logic [SizeW-1:0] rem;
    logic [QuotW-1:0] work;
  } div_state_t;

  function automatic div_state_t div_step(div_state_t s, logic [SizeW-1:0] d);
    logic [SizeW:0] t;
    logic [SizeW:0] diff;
    logic           take;
    div_state_t     r;
    t      = {s.rem, s.work[QuotW-1]};
    diff   = t - {1'b0, d};
    take   = (t >= {1'b0, d});
    r.rem  = take ? diff[SizeW-1:0] : t[SizeW-1:0];
    r.work = {s.work[QuotW-2:0], take};
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/lsnm_cfg.sv */
// ----------------------------------------------------------------------------
// Letterbox nearest scaler map configuration registers
// Holds the frame, box and source geometry; size writes saturate at MAX_DIM.
// ----------------------------------------------------------------------------
`default_nettype none

module lsnm_cfg
  import lsnm_pkg::*;
#(
  parameter int MAX_DIM = 8192
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_en_i,
  input  wire logic [CfgIdxW-1:0] wr_index_i,
  input  wire logic [SizeW-1:0]   wr_data_i,
  output cfg_t                    cfg_o
);

  localparam logic [16:0] MaxDim = 17'(MAX_DIM);

  cfg_t             cfg_q;
  logic [SizeW-1:0] size_val;

  always_comb begin
    if ({3'b000, wr_data_i} > MaxDim) begin
      size_val = MaxDim[SizeW-1:0];
    end else begin
      size_val = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= FrameWidthRst;
      cfg_q.frame_height  <= FrameHeightRst;
      cfg_q.box_left      <= BoxLeftRst;
      cfg_q.box_top       <= BoxTopRst;
      cfg_q.box_width     <= BoxWidthRst;
      cfg_q.box_height    <= BoxHeightRst;
      cfg_q.source_width  <= SourceWidthRst;
      cfg_q.source_height <= SourceHeightRst;
    end else if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CFG_FRAME_WIDTH:   cfg_q.frame_width   <= size_val;
        CFG_FRAME_HEIGHT:  cfg_q.frame_height  <= size_val;
        CFG_BOX_LEFT:      cfg_q.box_left      <= wr_data_i[PosW-1:0];
        CFG_BOX_TOP:       cfg_q.box_top       <= wr_data_i[PosW-1:0];
        CFG_BOX_WIDTH:     cfg_q.box_width     <= size_val;
        CFG_BOX_HEIGHT:    cfg_q.box_height    <= size_val;
        CFG_SOURCE_WIDTH:  cfg_q.source_width  <= size_val;
        CFG_SOURCE_HEIGHT: cfg_q.source_height <= size_val;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* design/lsnm_front.sv */
// ----------------------------------------------------------------------------
// Letterbox nearest scaler map front end
// Stage one checks frame and box bounds and forms box offsets; stage two
// multiplies each offset by the source size.
// ----------------------------------------------------------------------------
`default_nettype none

module lsnm_front
  import lsnm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire in_t               pos_i,
  input  wire cfg_t              cfg_i,
  output flags_t                 flags_o,
  output logic [ProdW-1:0]       prod_x_o,
  output logic [ProdW-1:0]       prod_y_o
);

  logic [PosW-1:0] off_x;
  logic [PosW-1:0] off_y;
  logic            hit_x;
  logic            hit_y;
  logic            outside;

  flags_t          flags1_q;
  flags_t          flags2_q;
  logic [PosW-1:0] off_x_q;
  logic [PosW-1:0] off_y_q;
  logic [ProdW-1:0] prod_x_q;
  logic [ProdW-1:0] prod_y_q;

  // An empty box never matches, since no offset is below a zero length.
  always_comb begin
    off_x   = pos_i.pos_x - cfg_i.box_left;
    off_y   = pos_i.pos_y - cfg_i.box_top;
    hit_x   = (pos_i.pos_x >= cfg_i.box_left) && ({1'b0, off_x} < cfg_i.box_width);
    hit_y   = (pos_i.pos_y >= cfg_i.box_top) && ({1'b0, off_y} < cfg_i.box_height);
    outside = ({1'b0, pos_i.pos_x} >= cfg_i.frame_width) ||
              ({1'b0, pos_i.pos_y} >= cfg_i.frame_height);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags1_q <= '0;
      flags2_q <= '0;
    end else begin
      flags1_q.valid   <= valid_i;
      flags1_q.outside <= outside;
      flags1_q.in_box  <= !outside && hit_x && hit_y;
      flags2_q         <= flags1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    off_x_q  <= off_x;
    off_y_q  <= off_y;
    prod_x_q <= ProdW'(off_x_q) * ProdW'(cfg_i.source_width);
    prod_y_q <= ProdW'(off_y_q) * ProdW'(cfg_i.source_height);
  end

  assign flags_o  = flags2_q;
  assign prod_x_o = prod_x_q;
  assign prod_y_o = prod_y_q;

endmodule

`default_nettype wire

/* design/lsnm_div.sv */
// ----------------------------------------------------------------------------
// Letterbox nearest scaler map divider
// Pipelined restoring divider: two quotient bits are resolved per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lsnm_div
  import lsnm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic [ProdW-1:0] dividend_i,
  input  wire logic [SizeW-1:0] divisor_i,
  output logic [QuotW-1:0]      quot_o
);

  div_state_t st_q [NumDivStages];
  div_state_t st_d [NumDivStages];

  // The quotient is known to fit QuotW bits, so the top dividend bits
  // already form a remainder below the divisor.
  always_comb begin
    div_state_t cur;
    for (int s = 0; s < NumDivStages; s++) begin
      if (s == 0) begin
        cur.rem  = SizeW'(dividend_i[ProdW-1:QuotW]);
        cur.work = dividend_i[QuotW-1:0];
      end else begin
        cur = st_q[s-1];
      end
      for (int k = 0; k < StepsPerStage; k++) begin
        cur = div_step(cur, divisor_i);
      end
      st_d[s] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NumDivStages; s++) begin
      st_q[s] <= st_d[s];
    end
  end

  assign quot_o = st_q[NumDivStages-1].work;

endmodule

`default_nettype wire

/* design/letterbox_nearest_scaler_map.sv */
// ----------------------------------------------------------------------------
// Letterbox nearest scaler map
// Maps an output frame position to a source pixel, a black bar, or a
// position beyond the frame, by nearest-neighbor scaling inside a box.
// ----------------------------------------------------------------------------
// Usage:
// A position beat is taken on every rising edge where start is high and busy
// is low. Busy never rises, so a new position may be offered every cycle and
// the block sustains one mapping per clock, as scanout needs.
// Each result appears on result_o for exactly one cycle, marked by
// result_valid_o. Results leave in the order the positions arrived. The
// receiver cannot stall this channel, and the pipeline never holds, so
// nothing is dropped or repeated.
// A position passes through the two front stages (bounds check, then
// offset times source size), the seven-stage divider that resolves two
// quotient bits per stage, and the output register that zeroes and saturates.
// Geometry registers are written through the cfg channel, which is always
// ready; they should be written only while no mapping is in flight.
// Reset clears the pipeline valid bits and loads a 640 by 480 frame with a
// full-frame box and a 640 by 480 source.
// ----------------------------------------------------------------------------
`default_nettype none

module letterbox_nearest_scaler_map
  import lsnm_pkg::*;
#(
  parameter int MAX_DIM = 8192
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_t                pos_i,
  output logic                    result_valid_o,
  output out_t                    result_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [SizeW-1:0]   cfg_data_i
);

  cfg_t             cfg;
  flags_t           front_flags;
  logic [ProdW-1:0] prod_x;
  logic [ProdW-1:0] prod_y;
  logic [QuotW-1:0] quot_x;
  logic [QuotW-1:0] quot_y;
  flags_t           flags_q [NumDivStages];
  flags_t           tail_flags;
  out_t             result_d;
  out_t             result_q;
  logic             result_valid_q;

  // The pipeline runs freely, so input and config beats are always taken.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  lsnm_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  lsnm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .pos_i    (pos_i),
    .cfg_i    (cfg),
    .flags_o  (front_flags),
    .prod_x_o (prod_x),
    .prod_y_o (prod_y)
  );

  // The divisors come straight from the registers, which the user must hold
  // still while mappings are in flight; the block itself does not enforce this.
  lsnm_div u_div_x (
    .clk_i      (clk_i),
    .dividend_i (prod_x),
    .divisor_i  (cfg.box_width),
    .quot_o     (quot_x)
  );

  lsnm_div u_div_y (
    .clk_i      (clk_i),
    .dividend_i (prod_y),
    .divisor_i  (cfg.box_height),
    .quot_o     (quot_y)
  );

  // The flags follow the divider through a delay line of equal length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumDivStages; s++) begin
        flags_q[s] <= '0;
      end
    end else begin
      flags_q[0] <= front_flags;
      for (int s = 1; s < NumDivStages; s++) begin
        flags_q[s] <= flags_q[s-1];
      end
    end
  end

  assign tail_flags = flags_q[NumDivStages-1];

  // Outside the picture both indexes read as zero. A quotient that does not
  // fit the index field is clipped to the largest index.
  always_comb begin
    result_d.in_picture    = tail_flags.in_box;
    result_d.outside_frame = tail_flags.outside;
    result_d.src_col       = '0;
    result_d.src_row       = '0;
    if (tail_flags.in_box) begin
      result_d.src_col = quot_x[QuotW-1] ? IndexMax : quot_x[PosW-1:0];
      result_d.src_row = quot_y[QuotW-1] ? IndexMax : quot_y[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= tail_flags.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire
